// File: rtl/wcsp_pkg.sv
package wcsp_pkg;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_input;
    logic       restart;
  } wcsp_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [15:0] format_tag;
    logic [31:0] payload_size;
    logic        fault_code;
    logic        final_item;
  } wcsp_out_t;

  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

  localparam logic [15:0] DEPTH_8  = 16'd8;
  localparam logic [15:0] DEPTH_16 = 16'd16;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  localparam logic [1:0] KIND_FORMAT  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic FAULT_DEPTH = 1'b0;
  localparam logic FAULT_TRUNC = 1'b1;

endpackage

// File: rtl/wcsp_parse.sv
module wcsp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  wcsp_pkg::wcsp_in_t  word_i,
  output logic                res_valid_o,
  output wcsp_pkg::wcsp_out_t res_o
);
  import wcsp_pkg::*;

  typedef enum logic [3:0] {
    PH_FMT_ID     = 4'd0,
    PH_SKIPA_LEN  = 4'd1,
    PH_SKIPA_BODY = 4'd2,
    PH_FMT_LEN    = 4'd3,
    PH_FMT_FIELDS = 4'd4,
    PH_FMT_EXTRA  = 4'd5,
    PH_DATA_ID    = 4'd6,
    PH_SKIPB_LEN  = 4'd7,
    PH_SKIPB_BODY = 4'd8,
    PH_DATA_LEN   = 4'd9,
    PH_PAYLOAD    = 4'd10,
    PH_PAD        = 4'd11,
    PH_DONE       = 4'd12,
    PH_HALTED     = 4'd13
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] len_q, len_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] depth_q, depth_d;
  logic [15:0] fmt_q, fmt_d;

  always_comb begin
    phase_e      ph;
    logic [3:0]  cnt;
    logic [31:0] sh;
    logic [31:0] cl;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [15:0] depth;
    logic [15:0] fmt;
    logic [7:0]  b;
    logic [31:0] word;
    logic        word_done;
    logic [31:0] skip_len;
    logic        skip_pad;
    logic [31:0] cl_n;
    logic [3:0]  cnt_n;
    logic        emit;
    logic [1:0]  e_kind;
    logic [7:0]  e_data;
    logic [31:0] e_size;
    logic        e_fault;
    logic        e_last;

    ph    = word_i.restart ? PH_FMT_ID : phase_q;
    cnt   = word_i.restart ? 4'd0  : cnt_q;
    sh    = word_i.restart ? 32'd0 : shift_q;
    cl    = word_i.restart ? 32'd0 : len_q;
    chan  = word_i.restart ? 16'd0 : chan_q;
    rate  = word_i.restart ? 32'd0 : rate_q;
    depth = word_i.restart ? 16'd0 : depth_q;
    fmt   = word_i.restart ? 16'd0 : fmt_q;
    b     = word_i.stream_byte;

    word      = sh | ({24'd0, b} << {cnt[1:0], 3'b000});
    word_done = (cnt[1:0] == 2'd3);
    skip_len  = (cl > FMT_BODY_BYTES) ? (cl - FMT_BODY_BYTES) : 32'd0;
    skip_pad  = cl[0];
    cl_n      = (cl != 32'd0) ? (cl - 32'd1) : cl;
    cnt_n     = (cl != 32'd0) ? cnt : 4'd0;

    phase_d = ph;
    cnt_d   = cnt;
    shift_d = sh;
    len_d   = cl;
    chan_d  = chan;
    rate_d  = rate;
    depth_d = depth;
    fmt_d   = fmt;

    emit    = 1'b0;
    e_kind  = KIND_FORMAT;
    e_data  = 8'd0;
    e_size  = 32'd0;
    e_fault = 1'b0;
    e_last  = 1'b0;

    if (ph == PH_DONE || ph == PH_HALTED || ph > PH_HALTED) begin
      phase_d = ph;
    end else if (word_i.end_of_input) begin
      if (ph == PH_PAD) begin
        phase_d = PH_DONE;
      end else begin
        phase_d = PH_HALTED;
        emit    = 1'b1;
        e_kind  = KIND_ERROR;
        e_fault = FAULT_TRUNC;
        e_last  = 1'b1;
      end
    end else begin
      case (ph)
        PH_FMT_ID, PH_DATA_ID, PH_SKIPA_LEN, PH_SKIPB_LEN, PH_FMT_LEN, PH_DATA_LEN: begin
          if (!word_done) begin
            shift_d = word;
            cnt_d   = cnt + 4'd1;
          end else begin
            shift_d = 32'd0;
            cnt_d   = 4'd0;
            case (ph)
              PH_FMT_ID: begin
                phase_d = (word == ID_FMT) ? PH_FMT_LEN : PH_SKIPA_LEN;
              end
              PH_DATA_ID: begin
                phase_d = (word == ID_DATA) ? PH_DATA_LEN : PH_SKIPB_LEN;
              end
              PH_SKIPA_LEN: begin
                len_d   = word;
                cnt_d   = {3'd0, word[0]};
                phase_d = (word == 32'd0) ? PH_FMT_ID : PH_SKIPA_BODY;
              end
              PH_SKIPB_LEN: begin
                len_d   = word;
                cnt_d   = {3'd0, word[0]};
                phase_d = (word == 32'd0) ? PH_DATA_ID : PH_SKIPB_BODY;
              end
              PH_FMT_LEN: begin
                len_d   = word;
                phase_d = PH_FMT_FIELDS;
              end
              default: begin
                len_d   = word;
                shift_d = word;
                phase_d = (word == 32'd0) ? PH_DONE : PH_PAYLOAD;
                emit    = 1'b1;
                e_kind  = KIND_FORMAT;
                e_size  = word;
                e_last  = (word == 32'd0);
              end
            endcase
          end
        end

        PH_FMT_FIELDS: begin
          if (cnt < 4'd2) begin
            fmt_d = fmt | ({8'd0, b} << {cnt[0], 3'b000});
          end else if (cnt < 4'd4) begin
            chan_d = chan | ({8'd0, b} << {cnt[0], 3'b000});
          end else if (cnt < 4'd8) begin
            rate_d = rate | ({24'd0, b} << {cnt[1:0], 3'b000});
          end else if (cnt >= 4'd14) begin
            depth_d = depth | ({8'd0, b} << {cnt[0], 3'b000});
          end
          cnt_d = cnt + 4'd1;
          if (cnt == 4'd15) begin
            cnt_d = 4'd0;
            if (depth_d != DEPTH_8 && depth_d != DEPTH_16 && depth_d != DEPTH_32) begin
              phase_d = PH_HALTED;
              emit    = 1'b1;
              e_kind  = KIND_ERROR;
              e_fault = FAULT_DEPTH;
              e_last  = 1'b1;
            end else begin
              len_d   = skip_len;
              cnt_d   = {3'd0, skip_pad};
              phase_d = (skip_len == 32'd0 && !skip_pad) ? PH_DATA_ID : PH_FMT_EXTRA;
            end
          end
        end

        PH_SKIPA_BODY, PH_FMT_EXTRA, PH_SKIPB_BODY: begin
          len_d = cl_n;
          cnt_d = cnt_n;
          if (cl_n == 32'd0 && cnt_n == 4'd0) begin
            phase_d = (ph == PH_SKIPA_BODY) ? PH_FMT_ID : PH_DATA_ID;
          end
        end

        PH_PAYLOAD: begin
          len_d = cl - 32'd1;
          if (len_d == 32'd0) begin
            phase_d = sh[0] ? PH_PAD : PH_DONE;
          end
          emit   = 1'b1;
          e_kind = KIND_PAYLOAD;
          e_data = b;
          e_size = sh;
          e_last = (len_d == 32'd0);
        end

        PH_PAD: begin
          phase_d = PH_DONE;
        end

        default: begin
          phase_d = ph;
        end
      endcase
    end

    res_valid_o         = accept_i && emit;
    res_o.result_kind   = e_kind;
    res_o.payload_byte  = e_data;
    res_o.channel_count = (e_kind == KIND_ERROR) ? 16'd0 : chan;
    res_o.rate_hz       = (e_kind == KIND_ERROR) ? 32'd0 : rate;
    res_o.sample_bits   = (e_kind == KIND_ERROR) ? 16'd0 : depth;
    res_o.format_tag    = (e_kind == KIND_ERROR) ? 16'd0 : fmt;
    res_o.payload_size  = (e_kind == KIND_ERROR) ? 32'd0 : e_size;
    res_o.fault_code    = e_fault;
    res_o.final_item    = e_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FMT_ID;
      cnt_q   <= 4'd0;
      shift_q <= 32'd0;
      len_q   <= 32'd0;
      chan_q  <= 16'd0;
      rate_q  <= 32'd0;
      depth_q <= 16'd0;
      fmt_q   <= 16'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      len_q   <= len_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      depth_q <= depth_d;
      fmt_q   <= fmt_d;
    end
  end

endmodule

// File: rtl/wcsp_skid.sv
module wcsp_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcsp_pkg::wcsp_out_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcsp_pkg::wcsp_out_t out_data_o
);
  import wcsp_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  wcsp_out_t main_q, main_d;
  wcsp_out_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = in_valid_i;
        main_d       = in_data_i;
      end
    end else if (in_valid_i && in_ready_o) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: rtl/wav_chunk_stream_parser_core.sv
// Parses the chunk stream of a wave file that follows the 12-byte RIFF/WAVE header, one byte
// word per cycle, and produces a format record followed by the payload bytes of the data chunk,
// or an error word on a bad bit depth or an early end of stream. Each accepted word is handled
// by the parse state registers, and any result is registered into a two-entry output buffer,
// so a new word can be accepted every cycle; in_ready_o drops only when the output side has
// stalled long enough to fill both buffer entries.
module wav_chunk_stream_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wcsp_pkg::wcsp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wcsp_pkg::wcsp_out_t out_data_o
);
  import wcsp_pkg::*;

  logic      accept;
  logic      res_valid;
  wcsp_out_t res;

  assign accept = in_valid_i && in_ready_o;

  wcsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wcsp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import wcsp_pkg::*;

  localparam int ITEM_TARGET   = 800;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_UNITS = 6000000;

  typedef enum logic [3:0] {
    SEEK_FMT_ID, SKIP_A_LEN, SKIP_A_BODY, FMT_LEN, FMT_FIELDS, FMT_EXTRA,
    SEEK_DATA_ID, SKIP_B_LEN, SKIP_B_BODY, DATA_LEN, PAYLOAD, PAY_PAD,
    STREAM_DONE, STREAM_HALTED
  } parse_phase_e;

  typedef struct {
    wcsp_in_t  word;
    logic      pinned;
    wcsp_out_t result;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  wcsp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  wcsp_out_t out_data_o;

  wav_chunk_stream_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  parse_phase_e phase;
  logic [31:0]  got_bytes;
  logic [31:0]  word_acc;
  logic [31:0]  remaining;
  logic [15:0]  fmt_channels;
  logic [31:0]  fmt_rate;
  logic [15:0]  fmt_depth;
  logic [15:0]  fmt_tag;

  wcsp_out_t pending_results[$];
  stim_row_t offered_rows[$];
  stim_row_t stream_rows[$];

  int mismatch_count = 0;
  int useful_items = 0;
  int gap_odds = 0;
  bit quiet = 1'b0;
  bit ready_calm = 1'b0;
  bit hold_request = 1'b0;
  bit restart_next = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    end
  endtask

  function automatic void clear_parser();
    phase = SEEK_FMT_ID;
    got_bytes = '0;
    word_acc = '0;
    remaining = '0;
    fmt_channels = '0;
    fmt_rate = '0;
    fmt_depth = '0;
    fmt_tag = '0;
  endfunction

  function automatic wcsp_out_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [31:0] size, input logic fault,
                                            input logic last);
    wcsp_out_t r;
    r = '0;
    r.result_kind = kind;
    r.payload_byte = data;
    r.fault_code = fault;
    r.final_item = last;
    if (kind != KIND_ERROR) begin
      r.channel_count = fmt_channels;
      r.rate_hz = fmt_rate;
      r.sample_bits = fmt_depth;
      r.format_tag = fmt_tag;
      r.payload_size = size;
    end
    return r;
  endfunction

  function automatic void start_skip(input logic [31:0] len, input logic pad,
                                     input parse_phase_e body, input parse_phase_e after);
    remaining = len;
    got_bytes = {31'd0, pad};
    if (len == 0 && !pad) begin
      phase = after;
    end else begin
      phase = body;
    end
  endfunction

  // Advances the parser by one accepted word; returns 1 when the word yields a result.
  function automatic bit predict_word(input wcsp_in_t w, output wcsp_out_t r);
    logic [31:0] word;
    logic [3:0]  idx;
    logic [7:0]  b;
    b = w.stream_byte;
    r = '0;
    if (w.restart) begin
      clear_parser();
    end
    if (phase >= STREAM_DONE) begin
      return 1'b0;
    end
    useful_items++;
    if (w.end_of_input) begin
      if (phase == PAY_PAD) begin
        phase = STREAM_DONE;
        return 1'b0;
      end
      phase = STREAM_HALTED;
      r = make_result(KIND_ERROR, 8'd0, 32'd0, FAULT_TRUNC, 1'b1);
      return 1'b1;
    end
    case (phase)
      SEEK_FMT_ID, SEEK_DATA_ID, SKIP_A_LEN, SKIP_B_LEN, FMT_LEN, DATA_LEN: begin
        word_acc = word_acc | ({24'd0, b} << {got_bytes[1:0], 3'b000});
        got_bytes++;
        if (got_bytes < 4) begin
          return 1'b0;
        end
        word = word_acc;
        word_acc = '0;
        got_bytes = '0;
        case (phase)
          SEEK_FMT_ID: phase = (word == ID_FMT) ? FMT_LEN : SKIP_A_LEN;
          SEEK_DATA_ID: phase = (word == ID_DATA) ? DATA_LEN : SKIP_B_LEN;
          SKIP_A_LEN: start_skip(word, word[0], SKIP_A_BODY, SEEK_FMT_ID);
          SKIP_B_LEN: start_skip(word, word[0], SKIP_B_BODY, SEEK_DATA_ID);
          FMT_LEN: begin
            remaining = word;
            phase = FMT_FIELDS;
          end
          default: begin
            remaining = word;
            word_acc = word;
            phase = (word == 0) ? STREAM_DONE : PAYLOAD;
            r = make_result(KIND_FORMAT, 8'd0, word, 1'b0, word == 0);
            return 1'b1;
          end
        endcase
        return 1'b0;
      end
      FMT_FIELDS: begin
        idx = got_bytes[3:0];
        if (idx < 2) begin
          fmt_tag = fmt_tag | ({8'd0, b} << {idx[0], 3'b000});
        end else if (idx < 4) begin
          fmt_channels = fmt_channels | ({8'd0, b} << {idx[0], 3'b000});
        end else if (idx < 8) begin
          fmt_rate = fmt_rate | ({24'd0, b} << {idx[1:0], 3'b000});
        end else if (idx >= 14) begin
          fmt_depth = fmt_depth | ({8'd0, b} << {idx[0], 3'b000});
        end
        got_bytes++;
        if (got_bytes < 16) begin
          return 1'b0;
        end
        got_bytes = '0;
        if (fmt_depth != DEPTH_8 && fmt_depth != DEPTH_16 && fmt_depth != DEPTH_32) begin
          phase = STREAM_HALTED;
          r = make_result(KIND_ERROR, 8'd0, 32'd0, FAULT_DEPTH, 1'b1);
          return 1'b1;
        end
        start_skip((remaining > FMT_BODY_BYTES) ? remaining - FMT_BODY_BYTES : 32'd0,
                   remaining[0], FMT_EXTRA, SEEK_DATA_ID);
        return 1'b0;
      end
      SKIP_A_BODY, FMT_EXTRA, SKIP_B_BODY: begin
        if (remaining > 0) begin
          remaining--;
        end else begin
          got_bytes = '0;
        end
        if (remaining == 0 && got_bytes == 0) begin
          phase = (phase == SKIP_A_BODY) ? SEEK_FMT_ID : SEEK_DATA_ID;
        end
        return 1'b0;
      end
      PAYLOAD: begin
        remaining--;
        if (remaining == 0) begin
          phase = word_acc[0] ? PAY_PAD : STREAM_DONE;
        end
        r = make_result(KIND_PAYLOAD, b, word_acc, 1'b0, remaining == 0);
        return 1'b1;
      end
      PAY_PAD: begin
        phase = STREAM_DONE;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : accept_side
    stim_row_t row;
    wcsp_out_t predicted;
    bit        produced;
    if (!rst_ni) begin
      clear_parser();
    end else if (in_valid_i && in_ready_o) begin
      row.pinned = 1'b0;
      if (offered_rows.size() != 0) begin
        row = offered_rows.pop_front();
      end
      produced = predict_word(in_data_i, predicted);
      if (row.pinned) begin
        if (!produced || predicted !== row.result) begin
          report_mismatch("directed word disagrees with the parser prediction");
        end
        pending_results.push_back(row.result);
      end else if (produced) begin
        pending_results.push_back(predicted);
      end
    end
  end

  always @(posedge clk_i) begin : result_side
    wcsp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_data_o));
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", out_data_o.result_kind, want.result_kind);
        check_field("payload_byte", out_data_o.payload_byte, want.payload_byte);
        check_field("channel_count", out_data_o.channel_count, want.channel_count);
        check_field("rate_hz", out_data_o.rate_hz, want.rate_hz);
        check_field("sample_bits", out_data_o.sample_bits, want.sample_bits);
        check_field("format_tag", out_data_o.format_tag, want.format_tag);
        check_field("payload_size", out_data_o.payload_size, want.payload_size);
        check_field("fault_code", out_data_o.fault_code, want.fault_code);
        check_field("final_item", out_data_o.final_item, want.final_item);
      end
    end
  end

  function automatic stim_row_t plain_row(input logic [7:0] b, input logic eoi = 1'b0,
                                          input logic rs = 1'b0);
    stim_row_t row;
    row.word = '0;
    row.word.stream_byte = b;
    row.word.end_of_input = eoi;
    row.word.restart = rs;
    row.pinned = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic stim_row_t fault_row(input logic [7:0] b, input logic eoi,
                                          input logic rs, input logic fault);
    stim_row_t row;
    row = plain_row(b, eoi, rs);
    row.pinned = 1'b1;
    row.result.result_kind = KIND_ERROR;
    row.result.fault_code = fault;
    row.result.final_item = 1'b1;
    return row;
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic eoi, input logic rs);
    stream_rows.push_back(plain_row(b, eoi, rs | restart_next));
    restart_next = 1'b0;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_item(b, 1'b0, 1'b0);
  endfunction

  function automatic void add_half(input logic [15:0] h);
    add_byte(h[7:0]);
    add_byte(h[15:8]);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    add_half(w[15:0]);
    add_half(w[31:16]);
  endfunction

  function automatic void add_foreign_chunk(input logic [31:0] misplaced_id);
    logic [31:0] len;
    len = $urandom_range(0, 7);
    add_word(($urandom_range(0, 2) == 0) ? misplaced_id : $urandom);
    add_word(len);
    repeat (len + len[0]) add_byte($urandom_range(0, 255));
  endfunction

  task automatic offer(input stim_row_t row);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= row.word;
    offered_rows.push_back(row);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic run_stream(input bit long_payload);
    logic [31:0] len;
    logic [15:0] depth;
    int          cut;
    stream_rows.delete();
    restart_next = 1'b1;
    if (!long_payload && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(8, 40)) begin
        add_item($urandom_range(0, 255), $urandom_range(0, 7) == 0,
                 $urandom_range(0, 15) == 0);
      end
    end else begin
      if (!long_payload) begin
        repeat ($urandom_range(0, 2)) add_foreign_chunk(ID_DATA);
      end
      add_word(ID_FMT);
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 15);
        1: len = $urandom_range(17, 24);
        default: len = FMT_BODY_BYTES;
      endcase
      add_word(len);
      add_half(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1);
      add_half($urandom_range(0, 65535));
      add_word($urandom);
      add_word($urandom);
      add_half($urandom_range(0, 65535));
      case ($urandom_range(0, 7))
        0: depth = $urandom_range(0, 65535);
        1: depth = DEPTH_8;
        2: depth = DEPTH_32;
        default: depth = DEPTH_16;
      endcase
      if (long_payload) begin
        depth = DEPTH_16;
      end
      add_half(depth);
      repeat (((len > FMT_BODY_BYTES) ? len - FMT_BODY_BYTES : 0) + len[0]) begin
        add_byte($urandom_range(0, 255));
      end
      if (!long_payload) begin
        repeat ($urandom_range(0, 2)) add_foreign_chunk(ID_FMT);
      end
      add_word(ID_DATA);
      if (long_payload) begin
        len = 40;
      end else if ($urandom_range(0, 15) == 0) begin
        len = 32'hFFFF_FFFF;
      end else begin
        len = $urandom_range(0, 20);
      end
      add_word(len);
      repeat ((len == 32'hFFFF_FFFF) ? 8 : len) add_byte($urandom_range(0, 255));
      if (len[0] && len <= 20 && $urandom_range(0, 3) != 0) begin
        add_byte($urandom_range(0, 255));
      end
      case (long_payload ? 3 : $urandom_range(0, 5))
        0: begin
          cut = $urandom_range(1, stream_rows.size() - 1);
          while (stream_rows.size() > cut) void'(stream_rows.pop_back());
          add_item($urandom_range(0, 255), 1'b1, 1'b0);
        end
        1: begin
          repeat ($urandom_range(1, 4)) add_byte($urandom_range(0, 255));
          add_item($urandom_range(0, 255), 1'b1, 1'b0);
        end
        2: ;
        default: add_item($urandom_range(0, 255), 1'b1, 1'b0);
      endcase
    end
    foreach (stream_rows[k]) offer(stream_rows[k]);
  endtask

  initial begin : ready_side
    int hold_count;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet && !ready_calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed_rows[27];
    int        stream_idx;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    directed_rows = '{
      fault_row(8'h00, 1'b1, 1'b1, FAULT_TRUNC),
      plain_row(8'h5A),
      plain_row(8'h66, 1'b0, 1'b1), plain_row(8'h6D), plain_row(8'h74), plain_row(8'h20),
      plain_row(8'h10), plain_row(8'h00), plain_row(8'h00), plain_row(8'h00),
      plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
      plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
      plain_row(8'h00), plain_row(8'h00), plain_row(8'h00), plain_row(8'h00),
      plain_row(8'h00), plain_row(8'h00),
      plain_row(8'hFF),
      fault_row(8'hFF, 1'b0, 1'b0, FAULT_DEPTH),
      plain_row(8'h00, 1'b1, 1'b0)
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_odds = 4;
    foreach (directed_rows[k]) offer(directed_rows[k]);
    drain_results();
    stream_idx = 0;
    while (useful_items < ITEM_TARGET) begin
      stream_idx++;
      quiet = (useful_items > ITEM_TARGET * 7 / 8);
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      ready_calm = ($urandom_range(0, 3) == 0);
      if (stream_idx == 4) begin
        gap_odds = 0;
        hold_request = 1'b1;
      end
      run_stream(stream_idx == 4);
      if (stream_idx == 2 || $urandom_range(0, 5) == 0) begin
        drain_results();
      end
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wcsp_pkg.sv
rtl/wcsp_parse.sv
rtl/wcsp_skid.sv
rtl/wav_chunk_stream_parser_core.sv
tb/sv/testbench.sv
